FILE: hw/rtl/mseu_pkg.sv
package mseu_pkg;

  localparam int NUM_CORES   = 8;
  localparam int NUM_SIGNALS = 16;

  localparam int CMD_W     = 3;
  localparam int SIGIDX_W  = 4;
  localparam int COREIDX_W = 3;
  localparam int STATUS_W  = 2;
  localparam int NOTIFY_W  = 8;
  localparam int FOUND_W   = 4;
  localparam int COUNT_W   = 5;
  localparam int CFG_W     = 5;

  localparam int CORE_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int SIG_W  = (NUM_SIGNALS > 1) ? $clog2(NUM_SIGNALS) : 1;
  localparam int LIM_W  = ($clog2(NUM_SIGNALS + 1) > CFG_W) ? $clog2(NUM_SIGNALS + 1) : CFG_W;
  localparam int IDX_W  = (CORE_W > SIG_W) ? CORE_W : SIG_W;
  localparam int CMP_W  = ((IDX_W > LIM_W) ? IDX_W : LIM_W) + 2;

  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(16);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_WAIT       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SIGNAL_ONE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SIGNAL_ALL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CHECK      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INIT       = 3'd4;

  localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STS_GRANTED = 2'd1;
  localparam logic [STATUS_W-1:0] STS_NONE    = 2'd2;
  localparam logic [STATUS_W-1:0] STS_RANGE   = 2'd3;

  typedef enum logic [2:0] {
    SEQ_IDLE = 3'b001,
    SEQ_STEP = 3'b010,
    SEQ_POST = 3'b100
  } seq_state_t;

  typedef struct packed {
    logic [SIG_W-1:0]  row;
    logic [CORE_W-1:0] core;
    logic              wait_set;
    logic              wake;
    logic              pend_clr;
    logic              clear_row;
  } store_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NOTIFY_W-1:0] notify;
    logic [FOUND_W-1:0]  found;
    logic [COUNT_W-1:0]  left;
  } result_t;

endpackage

FILE: hw/rtl/mseu_store.sv
module mseu_store import mseu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  store_op_t          op,
  output logic               wait_bit,
  output logic               pend_bit,
  output logic [COUNT_W-1:0] count
);

  logic [NUM_CORES-1:0] waiting_r [NUM_SIGNALS];
  logic [NUM_CORES-1:0] pending_r [NUM_SIGNALS];
  logic [COUNT_W-1:0]   count_r   [NUM_CORES];

  assign wait_bit = waiting_r[op.row][op.core];
  assign pend_bit = pending_r[op.row][op.core];
  assign count    = count_r[op.core];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SIGNALS; i++) begin
        waiting_r[i] <= '0;
        pending_r[i] <= '0;
      end
      for (int i = 0; i < NUM_CORES; i++) begin
        count_r[i] <= '0;
      end
    end else begin
      if (op.wait_set) begin
        waiting_r[op.row][op.core] <= 1'b1;
      end
      if (op.wake) begin
        waiting_r[op.row][op.core] <= 1'b0;
        pending_r[op.row][op.core] <= 1'b1;
        if (count_r[op.core] != COUNT_MAX) begin
          count_r[op.core] <= count_r[op.core] + COUNT_W'(1);
        end
      end
      if (op.pend_clr) begin
        pending_r[op.row][op.core] <= 1'b0;
        if (count_r[op.core] != '0) begin
          count_r[op.core] <= count_r[op.core] - COUNT_W'(1);
        end
      end
      if (op.clear_row) begin
        waiting_r[op.row] <= '0;
        pending_r[op.row] <= '0;
      end
    end
  end

endmodule

FILE: hw/rtl/mseu_seq.sv
module mseu_seq import mseu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [CMD_W-1:0]     cmd_in,
  input  logic [SIGIDX_W-1:0]  sig_in,
  input  logic [COREIDX_W-1:0] core_in,
  input  logic [LIM_W-1:0]     limit,
  input  logic                 out_free,
  input  logic                 wait_bit,
  input  logic                 pend_bit,
  input  logic [COUNT_W-1:0]   count,
  output store_op_t            op,
  output logic                 busy,
  output logic                 done,
  output result_t              result
);

  seq_state_t          state_r, state_nxt;
  logic [CMD_W-1:0]    cmd_r;
  logic [SIG_W-1:0]    sig_r;
  logic [CORE_W-1:0]   core_r;
  logic                range_err_r;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  result_t             res_r, res_nxt;
  logic                sig_ok, core_ok, range_err;
  logic                last_core, last_sig;

  assign sig_ok  = CMP_W'(sig_in) < CMP_W'(limit);
  assign core_ok = CMP_W'(core_in) < CMP_W'(NUM_CORES);

  always_comb begin
    unique case (cmd_in)
      CMD_WAIT:                                 range_err = !sig_ok || !core_ok;
      CMD_SIGNAL_ONE, CMD_SIGNAL_ALL, CMD_INIT: range_err = !sig_ok;
      CMD_CHECK:                                range_err = !core_ok;
      default:                                  range_err = 1'b0;
    endcase
  end

  assign last_core = CMP_W'(idx_r) == CMP_W'(NUM_CORES - 1);
  assign last_sig  = (CMP_W'(idx_r) + CMP_W'(1)) >= CMP_W'(limit);

  assign busy   = state_r != SEQ_IDLE;
  assign done   = (state_r == SEQ_POST) && out_free;
  assign result = res_r;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    res_nxt      = res_r;
    op           = '0;
    op.row       = sig_r;
    op.core      = core_r;
    if (cmd_r == CMD_SIGNAL_ONE || cmd_r == CMD_SIGNAL_ALL) begin
      op.core = idx_r[CORE_W-1:0];
    end else if (cmd_r == CMD_CHECK) begin
      op.row = idx_r[SIG_W-1:0];
    end
    unique case (state_r)
      SEQ_IDLE: begin
        if (start) begin
          state_nxt = SEQ_STEP;
          idx_nxt   = '0;
          res_nxt   = '0;
        end
      end
      SEQ_STEP: begin
        state_nxt = SEQ_POST;
        if (range_err_r) begin
          res_nxt.status = STS_RANGE;
        end else begin
          unique case (cmd_r)
            CMD_WAIT: op.wait_set  = 1'b1;
            CMD_INIT: op.clear_row = 1'b1;
            CMD_SIGNAL_ONE, CMD_SIGNAL_ALL: begin
              if (wait_bit) begin
                op.wake        = 1'b1;
                res_nxt.notify = res_r.notify | (NOTIFY_W'(1) << idx_r);
                res_nxt.status = STS_GRANTED;
              end
              if (!((cmd_r == CMD_SIGNAL_ONE) && wait_bit) && !last_core) begin
                state_nxt = SEQ_STEP;
                idx_nxt   = idx_r + IDX_W'(1);
              end
            end
            CMD_CHECK: begin
              if (limit == '0) begin
                res_nxt.status = STS_NONE;
                res_nxt.left   = count;
              end else if (pend_bit) begin
                op.pend_clr    = 1'b1;
                res_nxt.status = STS_OK;
                res_nxt.found  = FOUND_W'(idx_r);
                res_nxt.left   = (count != '0) ? count - COUNT_W'(1) : '0;
              end else if (last_sig) begin
                res_nxt.status = STS_NONE;
                res_nxt.left   = count;
              end else begin
                state_nxt = SEQ_STEP;
                idx_nxt   = idx_r + IDX_W'(1);
              end
            end
            default: ;
          endcase
        end
      end
      SEQ_POST: begin
        if (out_free) begin
          state_nxt = SEQ_IDLE;
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    res_r <= res_nxt;
    if (state_r == SEQ_IDLE && start) begin
      cmd_r       <= cmd_in;
      sig_r       <= SIG_W'(sig_in);
      core_r      <= CORE_W'(core_in);
      range_err_r <= range_err;
    end
  end

endmodule

FILE: hw/rtl/multicore_signal_event_unit_core.sv
// Inter-core signal/broadcast unit: waiting and pending bits per signal and core,
// plus a pending count per core.
// Input channel (in_valid/in_stall) carries one command word: wait, signal one,
// signal all, check or init, with a signal index and a calling core index.
// Output channel (out_valid/out_stall) returns one result word per command:
// status, notify mask, found signal and the core's remaining pending count.
// cfg_wr_en/cfg_wr_data write the number of signals in use; write only when idle.
// One command is processed at a time by a sequencer driving a read/modify step on
// the bit tables (a whole-row clear for init), one core or one signal per cycle.
// Sequencer steps per command: 1 for wait, init, unused commands and range errors; for
// signal one, cores scanned up to the first waiter (all NUM_CORES if none); NUM_CORES
// for signal all; for check, signals scanned up to the first pending one, at least 1.
// The post state then hands the result to the output register; in_stall stays high
// until the sequencer is idle again, so a new word is taken only after the last is done.
// A result held by out_stall keeps the sequencer in its post state with in_stall
// high until the output register frees up.
// Reset clears all bit tables and counts and sets signals in use to 16.
module multicore_signal_event_unit_core import mseu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [SIGIDX_W-1:0]  in_signal_index,
  input  logic [COREIDX_W-1:0] in_core_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  out_status,
  output logic [NOTIFY_W-1:0]  out_notify_mask,
  output logic [FOUND_W-1:0]   out_found_signal,
  output logic [COUNT_W-1:0]   out_pending_left,
  input  logic                 cfg_wr_en,
  input  logic [CFG_W-1:0]     cfg_wr_data
);

  logic [CFG_W-1:0] siu_r;
  logic [LIM_W-1:0] limit;
  logic             out_valid_r;
  result_t          out_r;
  logic             out_free;
  logic             busy, done, start;
  store_op_t        op;
  logic             wait_bit, pend_bit;
  logic [COUNT_W-1:0] count;
  result_t          result;

  assign limit    = (CMP_W'(siu_r) < CMP_W'(NUM_SIGNALS)) ? LIM_W'(siu_r) : LIM_W'(NUM_SIGNALS);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = busy;
  assign start    = in_valid && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      siu_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      siu_r <= cfg_wr_data;
    end
  end

  mseu_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .cmd_in   (in_command),
    .sig_in   (in_signal_index),
    .core_in  (in_core_index),
    .limit    (limit),
    .out_free (out_free),
    .wait_bit (wait_bit),
    .pend_bit (pend_bit),
    .count    (count),
    .op       (op),
    .busy     (busy),
    .done     (done),
    .result   (result)
  );

  mseu_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .wait_bit (wait_bit),
    .pend_bit (pend_bit),
    .count    (count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_notify_mask  = out_r.notify;
  assign out_found_signal = out_r.found;
  assign out_pending_left = out_r.left;

endmodule
